### rtl/small_language_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the small language tokenizer
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef SMALL_LANGUAGE_TOKENIZER_MACROS_SVH
`define SMALL_LANGUAGE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

// Next-cycle implication that is also checked across reset.
`define SLT_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tokenizer assertion failed");

`endif

### rtl/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// Types, codes, keyword tables and character classes of the tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int NUM_KW          = 5;
    localparam int KW_SLOTS        = 8;

    typedef enum logic [3:0] {
        KIND_TYPE     = 4'd0,
        KIND_PRINT    = 4'd1,
        KIND_IF       = 4'd2,
        KIND_ELSE     = 4'd3,
        KIND_IDENT    = 4'd4,
        KIND_NUMBER   = 4'd5,
        KIND_STRING   = 4'd6,
        KIND_OPERATOR = 4'd7,
        KIND_PUNCT    = 4'd8,
        KIND_EOF      = 4'd9,
        KIND_BAD_CHAR = 4'd10,
        KIND_UNCLOSED = 4'd11
    } kind_t;

    typedef enum logic [5:0] {
        MODE_IDLE   = 6'b000001,
        MODE_IDENT  = 6'b000010,
        MODE_NUMBER = 6'b000100,
        MODE_STRING = 6'b001000,
        MODE_LINE   = 6'b010000,
        MODE_BLOCK  = 6'b100000
    } mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [23:0] start;
        logic [23:0] len;
        logic [7:0]  ch;
        logic        last;
    } rec_t;

    localparam logic [7:0] KW_TEXT [NUM_KW][KW_SLOTS] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"s", "t", "r", "i",   "n",   "g",   8'h00, 8'h00},
        '{"p", "r", "i", "n",   "t",   8'h00, 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e",   8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd6, 3'd5, 3'd2, 3'd4};

    localparam kind_t KW_KIND [NUM_KW] = '{KIND_TYPE, KIND_TYPE, KIND_PRINT, KIND_IF,
                                           KIND_ELSE};

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return c == "=" || c == "+" || c == "-" || c == "/" || c == "*";
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == ";" || c == "(" || c == ")";
    endfunction

    function automatic rec_t make_rec(input kind_t kind, input logic [23:0] start,
                                      input logic [23:0] len, input logic [7:0] ch);
        rec_t r;
        r.kind  = kind;
        r.start = start;
        r.len   = len;
        r.ch    = ch;
        r.last  = 1'b0;
        return r;
    endfunction

endpackage

### rtl/slt_core.sv
// ----------------------------------------------------------------------------
// slt_core
// Lexer state registers and the single-step next-state and record logic.
// ----------------------------------------------------------------------------
module slt_core #(
    parameter int OFFSET_BITS = slt_pkg::OFFSET_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           go,
    input  logic           in_mode,
    input  logic [7:0]     in_char,
    output slt_pkg::rec_t  rec0,
    output slt_pkg::rec_t  rec1,
    output logic [1:0]     rec_count
);

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    slt_pkg::mode_t           mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]   begin_reg, begin_next;
    logic [slt_pkg::NUM_KW-1:0] kw_reg, kw_next;
    logic                     err_reg, err_next;

    logic [OFFSET_BITS-1:0]   diff;
    logic [OFFSET_BITS-1:0]   pos_adv;
    logic                     pos_sat;
    logic [2:0]               idx;
    logic [slt_pkg::NUM_KW-1:0] track_mask;
    logic [slt_pkg::NUM_KW-1:0] start_mask;
    slt_pkg::kind_t           ident_kind;

    slt_pkg::mode_t           idle_mode;
    logic                     idle_begin_set;
    logic [OFFSET_BITS-1:0]   idle_begin;
    logic                     idle_kw_set;
    logic                     idle_emit;
    slt_pkg::kind_t           idle_kind;
    logic                     idle_err;

    logic                     do_idle;
    logic                     tok_valid;
    logic                     b_valid;
    slt_pkg::rec_t            tok_rec;
    slt_pkg::rec_t            b_rec;

    function automatic logic [23:0] to_out(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+23:0] w;
        w = {24'd0, v};
        return w[23:0];
    endfunction

    assign diff    = pos_reg - begin_reg;
    assign pos_sat = (pos_reg == POS_MAX);
    assign pos_adv = pos_sat ? pos_reg : pos_reg + 1'b1;
    assign idx     = diff[2:0];

    always_comb begin
        for (int k = 0; k < slt_pkg::NUM_KW; k++) begin
            track_mask[k] = kw_reg[k] && (idx < slt_pkg::KW_LEN[k])
                            && (slt_pkg::KW_TEXT[k][idx] == in_char);
            start_mask[k] = !pos_sat && (slt_pkg::KW_TEXT[k][0] == in_char);
        end
        if (pos_sat || diff >= OFFSET_BITS'(6)) begin
            track_mask = '0;
        end
    end

    always_comb begin
        ident_kind = slt_pkg::KIND_IDENT;
        for (int k = slt_pkg::NUM_KW - 1; k >= 0; k--) begin
            if (kw_reg[k] && diff == OFFSET_BITS'(slt_pkg::KW_LEN[k])) begin
                ident_kind = slt_pkg::KW_KIND[k];
            end
        end
    end

    always_comb begin
        idle_mode      = slt_pkg::MODE_IDLE;
        idle_begin_set = 1'b0;
        idle_begin     = pos_reg;
        idle_kw_set    = 1'b0;
        idle_emit      = 1'b0;
        idle_kind      = slt_pkg::KIND_BAD_CHAR;
        idle_err       = 1'b0;
        if (in_char == "#") begin
            idle_mode = slt_pkg::MODE_LINE;
        end else if (in_char == "~") begin
            idle_mode = slt_pkg::MODE_BLOCK;
        end else if (slt_pkg::is_space(in_char)) begin
            idle_mode = slt_pkg::MODE_IDLE;
        end else if (slt_pkg::is_alpha(in_char)) begin
            idle_mode      = slt_pkg::MODE_IDENT;
            idle_begin_set = 1'b1;
            idle_kw_set    = 1'b1;
        end else if (slt_pkg::is_digit(in_char)) begin
            idle_mode      = slt_pkg::MODE_NUMBER;
            idle_begin_set = 1'b1;
        end else if (in_char == "\"") begin
            idle_mode      = slt_pkg::MODE_STRING;
            idle_begin_set = 1'b1;
            idle_begin     = pos_adv;
        end else if (slt_pkg::is_operator(in_char)) begin
            idle_emit = 1'b1;
            idle_kind = slt_pkg::KIND_OPERATOR;
        end else if (slt_pkg::is_punct(in_char)) begin
            idle_emit = 1'b1;
            idle_kind = slt_pkg::KIND_PUNCT;
        end else begin
            idle_emit = 1'b1;
            idle_err  = 1'b1;
        end
    end

    always_comb begin
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        begin_next = begin_reg;
        kw_next    = kw_reg;
        err_next   = err_reg;
        do_idle    = 1'b0;
        tok_valid  = 1'b0;
        b_valid    = 1'b0;
        tok_rec    = slt_pkg::make_rec(ident_kind, to_out(begin_reg), to_out(diff), 8'd0);
        b_rec      = slt_pkg::make_rec(slt_pkg::KIND_EOF, to_out(pos_reg), 24'd0, 8'd0);
        if (in_mode) begin
            if (!err_reg) begin
                if (mode_reg == slt_pkg::MODE_STRING) begin
                    b_valid = 1'b1;
                    b_rec   = slt_pkg::make_rec(slt_pkg::KIND_UNCLOSED, to_out(begin_reg),
                                                to_out(diff), 8'd0);
                end else begin
                    b_valid = 1'b1;
                    if (mode_reg == slt_pkg::MODE_IDENT) begin
                        tok_valid = 1'b1;
                    end else if (mode_reg == slt_pkg::MODE_NUMBER) begin
                        tok_valid    = 1'b1;
                        tok_rec.kind = slt_pkg::KIND_NUMBER;
                    end
                end
            end
            mode_next  = slt_pkg::MODE_IDLE;
            pos_next   = '0;
            begin_next = '0;
            kw_next    = '1;
            err_next   = 1'b0;
        end else if (err_reg) begin
            pos_next = pos_adv;
        end else begin
            case (mode_reg)
                slt_pkg::MODE_IDENT: begin
                    if (slt_pkg::is_alpha(in_char) || slt_pkg::is_digit(in_char)
                        || in_char == "_") begin
                        kw_next  = track_mask;
                        pos_next = pos_adv;
                    end else begin
                        tok_valid = 1'b1;
                        do_idle   = 1'b1;
                    end
                end
                slt_pkg::MODE_NUMBER: begin
                    if (slt_pkg::is_digit(in_char)) begin
                        pos_next = pos_adv;
                    end else begin
                        tok_valid    = 1'b1;
                        tok_rec.kind = slt_pkg::KIND_NUMBER;
                        do_idle      = 1'b1;
                    end
                end
                slt_pkg::MODE_STRING: begin
                    if (in_char == "\"") begin
                        b_valid   = 1'b1;
                        b_rec     = slt_pkg::make_rec(slt_pkg::KIND_STRING,
                                                      to_out(begin_reg), to_out(diff), 8'd0);
                        mode_next = slt_pkg::MODE_IDLE;
                    end
                    pos_next = pos_adv;
                end
                slt_pkg::MODE_LINE: begin
                    if (in_char == 8'h0A) begin
                        mode_next = slt_pkg::MODE_IDLE;
                    end
                    pos_next = pos_adv;
                end
                slt_pkg::MODE_BLOCK: begin
                    if (in_char == "~") begin
                        mode_next = slt_pkg::MODE_IDLE;
                    end
                    pos_next = pos_adv;
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
            if (do_idle) begin
                mode_next = idle_mode;
                pos_next  = pos_adv;
                err_next  = idle_err;
                b_valid   = idle_emit;
                b_rec     = slt_pkg::make_rec(idle_kind, to_out(pos_reg), 24'd1, in_char);
                if (idle_begin_set) begin
                    begin_next = idle_begin;
                end
                if (idle_kw_set) begin
                    kw_next = start_mask;
                end
            end
        end
    end

    always_comb begin
        rec_count = {1'b0, tok_valid} + {1'b0, b_valid};
        rec0      = tok_valid ? tok_rec : b_rec;
        rec1      = b_rec;
        rec0.last = (rec_count == 2'd1);
        rec1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= slt_pkg::MODE_IDLE;
            pos_reg   <= '0;
            begin_reg <= '0;
            kw_reg    <= '1;
            err_reg   <= 1'b0;
        end else if (go) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            begin_reg <= begin_next;
            kw_reg    <= kw_next;
            err_reg   <= err_next;
        end
    end

endmodule

### rtl/slt_outq.sv
// ----------------------------------------------------------------------------
// slt_outq
// Two-entry result queue that takes up to two records per cycle when it has room.
// ----------------------------------------------------------------------------
module slt_outq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          go,
    input  logic [1:0]    push_count,
    input  slt_pkg::rec_t rec0,
    input  slt_pkg::rec_t rec1,
    output logic          room,
    output logic          m_tvalid,
    input  logic          m_tready,
    output slt_pkg::rec_t m_rec
);

    logic [1:0]    occ_reg, occ_next;
    slt_pkg::rec_t q0_reg, q0_next;
    slt_pkg::rec_t q1_reg, q1_next;
    logic          pop;
    logic [1:0]    occ_pop;
    logic [2:0]    fill;
    logic [1:0]    push;

    assign pop     = (occ_reg != 2'd0) && m_tready;
    assign occ_pop = occ_reg - {1'b0, pop};
    assign fill    = {1'b0, occ_pop} + {1'b0, push_count};
    assign room    = (fill <= 3'd2);
    assign push    = go ? push_count : 2'd0;

    always_comb begin
        occ_next = occ_pop + push;
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        if (occ_pop == 2'd2) begin
            q0_next = q0_reg;
            q1_next = q1_reg;
        end else if (occ_pop == 2'd1) begin
            q0_next = pop ? q1_reg : q0_reg;
            q1_next = rec0;
        end else begin
            q0_next = rec0;
            q1_next = rec1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 2'd0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign m_tvalid = (occ_reg != 2'd0);
    assign m_rec    = q0_reg;

endmodule

### rtl/small_language_tokenizer.sv
// Input: an accepted byte is registered, then its records are written into the result queue.
// Throughput: one input item per cycle while the result queue has room; an item that
// gives two records fills the two-entry result queue.
// Reset: synchronous, active low; the lexer returns to idle between tokens at
// offset zero, and both the input register and the result queue empty.
// ----------------------------------------------------------------------------
// small_language_tokenizer
// Streaming lexer that turns source bytes into token records.
// ----------------------------------------------------------------------------
module small_language_tokenizer #(
    parameter int OFFSET_BITS = slt_pkg::OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_byte[7:0]
    input  logic        s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // start_offset[23:0], token_length[23:0], char_value[7:0]
    output logic [3:0]  m_tuser,   // token_kind[3:0]
    output logic        m_tlast
);

    logic          in_valid_reg;
    logic          in_mode_reg;
    logic [7:0]    in_char_reg;
    logic          go;
    logic          room;
    logic [1:0]    rec_count;
    slt_pkg::rec_t rec0;
    slt_pkg::rec_t rec1;
    slt_pkg::rec_t m_rec;

    assign go       = in_valid_reg && room;
    assign s_tready = !in_valid_reg || go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_char_reg <= s_tdata;
        end
    end

    slt_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .in_mode   (in_mode_reg),
        .in_char   (in_char_reg),
        .rec0      (rec0),
        .rec1      (rec1),
        .rec_count (rec_count)
    );

    slt_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .go         (go),
        .push_count (rec_count),
        .rec0       (rec0),
        .rec1       (rec1),
        .room       (room),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_rec      (m_rec)
    );

    assign m_tdata = {m_rec.ch, m_rec.len, m_rec.start};
    assign m_tuser = m_rec.kind;
    assign m_tlast = m_rec.last;

endmodule

### rtl/slt_checker.sv
// ----------------------------------------------------------------------------
// slt_checker
// Port-level assertions on the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "small_language_tokenizer_macros.svh"

module slt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    `SLT_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    `SLT_ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

    `SLT_ASSERT_NOW(a_end_is_last, aclk, aresetn,
        m_tvalid && (m_tuser == slt_pkg::KIND_EOF || m_tuser == slt_pkg::KIND_UNCLOSED),
        m_tlast)

    `SLT_ASSERT_NOW(a_char_only_single, aclk, aresetn,
        m_tvalid && m_tuser != slt_pkg::KIND_OPERATOR && m_tuser != slt_pkg::KIND_PUNCT
        && m_tuser != slt_pkg::KIND_BAD_CHAR,
        m_tdata[55:48] == 8'd0)

endmodule

bind small_language_tokenizer slt_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

### sim/small_language_tokenizer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Streams source bytes and end-of-input requests into the tokenizer and checks
// every token record against a cycle-free model of the lexer or a record given
// in the opening table. A short opening sequence covers the corner cases, then
// random programs, noise and stalls on both sides follow.
// ----------------------------------------------------------------------------
module small_language_tokenizer_test;

    localparam int unsigned RANDOM_ITEMS    = 1500;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES    = 100;
    localparam int unsigned CYCLE_LIMIT     = 800000;
    localparam logic [23:0] POS_TOP         = '1;

    typedef struct packed {
        logic            eoi;
        logic [7:0]      ch;
        logic            typed;
        slt_pkg::kind_t  want_kind;
        logic [23:0]     want_start;
        logic [23:0]     want_len;
        logic [7:0]      want_ch;
    } lex_item_t;

    // Rows with typed set carry their record in the row itself; the other rows
    // are checked against the lexer model.
    localparam lex_item_t OPENING [25] = '{
        '{1'b1, 8'hFF, 1'b1, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "i",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "f",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "(",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "7",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "9",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "*",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "\"",  1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "a",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "\"",  1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "#",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "x",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, 8'h0A, 1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "~",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "~",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "=",   1'b1, slt_pkg::KIND_OPERATOR, 24'd14, 24'd1, "="},
        '{1'b0, " ",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "x",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b1, 8'h00, 1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "\"",  1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b0, "b",   1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b1, 8'h00, 1'b1, slt_pkg::KIND_UNCLOSED, 24'd1,  24'd1, 8'd0},
        '{1'b0, 8'h00, 1'b1, slt_pkg::KIND_BAD_CHAR, 24'd0,  24'd1, 8'd0},
        '{1'b0, 8'hFF, 1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0},
        '{1'b1, 8'hFF, 1'b0, slt_pkg::KIND_EOF,      24'd0,  24'd0, 8'd0}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // char_byte[7:0]
    logic        s_tuser;   // mode[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // start_offset[23:0], token_length[23:0], char_value[7:0]
    logic [3:0]  m_tuser;   // token_kind[3:0]
    logic        m_tlast;

    lex_item_t      offer;
    lex_item_t      feed [$];
    slt_pkg::rec_t  due_tokens [$];
    slt_pkg::rec_t  fresh [$];

    slt_pkg::mode_t lx_state;
    logic [23:0]    cur_pos;
    logic [23:0]    tok_start;
    logic [4:0]     kw_live;
    logic           err_flag;

    int unsigned errors = 0;
    int unsigned cycles = 0;

    string kw_word [5]  = '{"int", "string", "print", "if", "else"};
    slt_pkg::kind_t kw_class [5] = '{slt_pkg::KIND_TYPE, slt_pkg::KIND_TYPE,
                                     slt_pkg::KIND_PRINT, slt_pkg::KIND_IF,
                                     slt_pkg::KIND_ELSE};
    string word_list [12] = '{"int", "string", "print", "if", "else", "in", "ifs",
                              "elsewhere", "strings", "Print", "prin", "i9"};
    string letters   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    string word_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    string digits    = "0123456789";
    string signs     = "=+-/*;()";
    string blanks    = " \t\n\013\014\r";

    small_language_tokenizer DUT (.*);

    always #2 aclk = ~aclk;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_numeral(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_op_char(logic [7:0] c);
        return c == "=" || c == "+" || c == "-" || c == "/" || c == "*";
    endfunction

    function automatic logic is_punct_char(logic [7:0] c);
        return c == ";" || c == "(" || c == ")";
    endfunction

    function automatic logic is_stray(logic [7:0] c);
        return !(is_letter(c) || is_numeral(c) || is_blank(c) || is_op_char(c) ||
                 is_punct_char(c) || c == "#" || c == "~" || c == "\"");
    endfunction

    function automatic logic [7:0] pick_char(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic int unsigned idle_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic lex_clear();
        lx_state  = slt_pkg::MODE_IDLE;
        cur_pos   = '0;
        tok_start = '0;
        kw_live   = '1;
        err_flag  = 1'b0;
    endtask

    task automatic step_pos();
        if (cur_pos != POS_TOP) cur_pos = cur_pos + 24'd1;
    endtask

    task automatic note_rec(slt_pkg::kind_t kind, logic [23:0] start, logic [23:0] len,
                            logic [7:0] ch);
        fresh.insert(fresh.size(), slt_pkg::rec_t'{kind, start, len, ch, 1'b0});
    endtask

    task automatic note_keyword(logic [7:0] c);
        logic [23:0] idx;
        idx = cur_pos - tok_start;
        if (cur_pos == POS_TOP || idx >= 24'd6) begin
            kw_live = '0;
        end else begin
            for (int k = 0; k < 5; k++) begin
                if (int'(idx) >= kw_word[k].len() || kw_word[k][int'(idx)] != c) begin
                    kw_live[k] = 1'b0;
                end
            end
        end
    endtask

    task automatic close_word();
        logic [23:0]    len;
        slt_pkg::kind_t kind;
        len  = cur_pos - tok_start;
        kind = slt_pkg::KIND_IDENT;
        for (int k = 4; k >= 0; k--) begin
            if (kw_live[k] && int'(len) == kw_word[k].len()) kind = kw_class[k];
        end
        note_rec(kind, tok_start, len, 8'h00);
    endtask

    task automatic lex_from_idle(logic [7:0] c);
        lx_state = slt_pkg::MODE_IDLE;
        if (c == "#") begin
            lx_state = slt_pkg::MODE_LINE;
        end else if (c == "~") begin
            lx_state = slt_pkg::MODE_BLOCK;
        end else if (is_blank(c)) begin
        end else if (is_letter(c)) begin
            lx_state  = slt_pkg::MODE_IDENT;
            tok_start = cur_pos;
            kw_live   = '1;
            note_keyword(c);
        end else if (is_numeral(c)) begin
            lx_state  = slt_pkg::MODE_NUMBER;
            tok_start = cur_pos;
        end else if (c == "\"") begin
            lx_state  = slt_pkg::MODE_STRING;
            tok_start = (cur_pos == POS_TOP) ? POS_TOP : cur_pos + 24'd1;
        end else if (is_op_char(c)) begin
            note_rec(slt_pkg::KIND_OPERATOR, cur_pos, 24'd1, c);
        end else if (is_punct_char(c)) begin
            note_rec(slt_pkg::KIND_PUNCT, cur_pos, 24'd1, c);
        end else begin
            note_rec(slt_pkg::KIND_BAD_CHAR, cur_pos, 24'd1, c);
            err_flag = 1'b1;
        end
        step_pos();
    endtask

    task automatic lex_byte(logic eoi, logic [7:0] c);
        fresh.delete();
        if (eoi) begin
            if (!err_flag) begin
                if (lx_state == slt_pkg::MODE_STRING) begin
                    note_rec(slt_pkg::KIND_UNCLOSED, tok_start, cur_pos - tok_start, 8'h00);
                end else begin
                    if (lx_state == slt_pkg::MODE_IDENT) begin
                        close_word();
                    end else if (lx_state == slt_pkg::MODE_NUMBER) begin
                        note_rec(slt_pkg::KIND_NUMBER, tok_start, cur_pos - tok_start,
                                 8'h00);
                    end
                    note_rec(slt_pkg::KIND_EOF, cur_pos, 24'd0, 8'h00);
                end
            end
            lex_clear();
        end else if (err_flag) begin
            step_pos();
        end else begin
            case (lx_state)
                slt_pkg::MODE_IDENT: begin
                    if (is_letter(c) || is_numeral(c) || c == "_") begin
                        note_keyword(c);
                        step_pos();
                    end else begin
                        close_word();
                        lex_from_idle(c);
                    end
                end
                slt_pkg::MODE_NUMBER: begin
                    if (is_numeral(c)) begin
                        step_pos();
                    end else begin
                        note_rec(slt_pkg::KIND_NUMBER, tok_start, cur_pos - tok_start,
                                 8'h00);
                        lex_from_idle(c);
                    end
                end
                slt_pkg::MODE_STRING: begin
                    if (c == "\"") begin
                        note_rec(slt_pkg::KIND_STRING, tok_start, cur_pos - tok_start,
                                 8'h00);
                        lx_state = slt_pkg::MODE_IDLE;
                    end
                    step_pos();
                end
                slt_pkg::MODE_LINE: begin
                    if (c == 8'h0A) lx_state = slt_pkg::MODE_IDLE;
                    step_pos();
                end
                slt_pkg::MODE_BLOCK: begin
                    if (c == "~") lx_state = slt_pkg::MODE_IDLE;
                    step_pos();
                end
                default: begin
                    lex_from_idle(c);
                end
            endcase
        end
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic add_item(logic eoi, logic [7:0] c);
        feed.insert(feed.size(),
                    lex_item_t'{eoi, c, 1'b0, slt_pkg::KIND_EOF, 24'd0, 24'd0, 8'd0});
    endtask

    task automatic add_filler(int unsigned n, logic [7:0] stop);
        logic [7:0] c;
        repeat (n) begin
            c = 8'($urandom_range(0, 255));
            if (c == stop) c = c ^ 8'h01;
            add_item(1'b0, c);
        end
    endtask

    always @(posedge aclk) begin : monitor
        slt_pkg::rec_t r;
        if (!aresetn) begin
            lex_clear();
        end else begin
            if (s_tvalid && s_tready) begin
                lex_byte(s_tuser, s_tdata);
                if (offer.typed) begin
                    fresh.delete();
                    note_rec(offer.want_kind, offer.want_start, offer.want_len,
                             offer.want_ch);
                end
                foreach (fresh[i]) begin
                    r      = fresh[i];
                    r.last = (i == fresh.size() - 1);
                    due_tokens.insert(due_tokens.size(), r);
                end
            end
            if (m_tvalid && m_tready) begin
                if (due_tokens.size() == 0) begin
                    $error("token record of kind %0d with none expected", m_tuser);
                    errors++;
                end else begin
                    r = due_tokens.pop_front();
                    compare_field("token_kind", r.kind, m_tuser);
                    compare_field("start_offset", r.start, m_tdata[23:0]);
                    compare_field("token_length", r.len, m_tdata[47:24]);
                    compare_field("char_value", r.ch, m_tdata[55:48]);
                    compare_field("last_of_run", r.last, m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : receiver
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        m_tready <= 1'b1;
        repeat (150) @(posedge aclk);
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12)) @(posedge aclk);
            if (idle_gap() > 0) begin
                m_tready <= 1'b0;
                repeat (idle_gap() + 1) @(posedge aclk);
            end
        end
    end

    initial begin : sender
        int unsigned gap;
        int unsigned tokens;
        int unsigned pick;
        logic        open_string;
        logic [7:0]  c;
        string       w;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        offer    <= '0;

        foreach (OPENING[i]) feed.insert(feed.size(), OPENING[i]);
        while (feed.size() < $size(OPENING) + RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                repeat ($urandom_range(1, 20)) add_item(1'b0, 8'($urandom_range(0, 255)));
                add_item(1'b1, 8'($urandom_range(0, 255)));
                continue;
            end
            tokens      = $urandom_range(3, 25);
            open_string = 1'b0;
            for (int t = 0; t < tokens && !open_string; t++) begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    w = word_list[$urandom_range(0, 11)];
                    for (int j = 0; j < w.len(); j++) add_item(1'b0, w[j]);
                end else if (pick < 35) begin
                    add_item(1'b0, pick_char(letters));
                    repeat ($urandom_range(0, 7)) add_item(1'b0, pick_char(word_tail));
                end else if (pick < 47) begin
                    repeat ($urandom_range(1, 5)) add_item(1'b0, pick_char(digits));
                end else if (pick < 57) begin
                    add_item(1'b0, "\"");
                    add_filler($urandom_range(0, 6), "\"");
                    add_item(1'b0, "\"");
                end else if (pick < 71) begin
                    add_item(1'b0, pick_char(signs));
                end else if (pick < 86) begin
                    add_item(1'b0, pick_char(blanks));
                end else if (pick < 91) begin
                    add_item(1'b0, "#");
                    add_filler($urandom_range(0, 6), 8'h0A);
                    add_item(1'b0, 8'h0A);
                end else if (pick < 96) begin
                    add_item(1'b0, "~");
                    add_filler($urandom_range(0, 6), "~");
                    add_item(1'b0, "~");
                end else if (pick < 98) begin
                    do c = 8'($urandom_range(0, 255)); while (!is_stray(c));
                    add_item(1'b0, c);
                end else begin
                    add_item(1'b0, "\"");
                    add_filler($urandom_range(0, 4), "\"");
                    open_string = 1'b1;
                end
                if ($urandom_range(0, 1) == 1) add_item(1'b0, pick_char(blanks));
            end
            add_item(1'b1, 8'($urandom_range(0, 255)));
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (feed[i]) begin
            gap = ((i >= 25 && i < 250) || (i % 400 >= 300)) ? 0 : idle_gap();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= feed[i].ch;
            s_tuser  <= feed[i].eoi;
            offer    <= feed[i];
            do @(posedge aclk); while (!s_tready);
        end
        s_tvalid <= 1'b0;

        while (due_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_core.sv
rtl/slt_outq.sv
rtl/small_language_tokenizer.sv
rtl/slt_checker.sv
sim/small_language_tokenizer_test.sv
